// ===== src/stdci_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial text display command interpreter package
// Shared types, command and status bundles, codes and character helpers.
// ----------------------------------------------------------------------------
package stdci_pkg;

	localparam int unsigned RESULT_LIMIT = 53;

	localparam logic [7:0] SKIP_BYTE  = 8'hFE;
	localparam logic [7:0] DIGIT_BASE = 8'h30;
	localparam logic [7:0] UPPER_BASE = 8'h37;
	localparam logic [7:0] LOWER_BASE = 8'h57;
	localparam logic [7:0] SPACE_CHAR = 8'd32;
	localparam logic [7:0] PRINT_LO   = 8'd32;
	localparam logic [7:0] PRINT_HI   = 8'd128;

	// Escape letters.
	localparam logic [7:0] ESC_START    = 8'h3F;
	localparam logic [7:0] ESC_HOME     = 8'h61;
	localparam logic [7:0] ESC_BKSP     = 8'h62;
	localparam logic [7:0] ESC_CLEAR    = 8'h66;
	localparam logic [7:0] ESC_BEEP     = 8'h67;
	localparam logic [7:0] ESC_GEOM     = 8'h47;
	localparam logic [7:0] ESC_LIGHT_B  = 8'h42;
	localparam logic [7:0] ESC_LIGHT_E  = 8'h45;
	localparam logic [7:0] ESC_INIT     = 8'h49;
	localparam logic [7:0] ESC_GLYPH    = 8'h44;
	localparam logic [7:0] ESC_BACK     = 8'h68;
	localparam logic [7:0] ESC_FWD      = 8'h69;
	localparam logic [7:0] ESC_RFEED    = 8'h6A;
	localparam logic [7:0] ESC_LFEED    = 8'h6B;
	localparam logic [7:0] ESC_CLRLINE  = 8'h6C;
	localparam logic [7:0] ESC_CRET     = 8'h6D;
	localparam logic [7:0] ESC_NEWLINE  = 8'h6E;
	localparam logic [7:0] ESC_TABSIZE  = 8'h73;
	localparam logic [7:0] ESC_TAB      = 8'h74;
	localparam logic [7:0] ESC_COLUMN   = 8'h78;
	localparam logic [7:0] ESC_LINE     = 8'h79;
	localparam logic [7:0] ESC_PIN_HIGH = 8'h48;
	localparam logic [7:0] ESC_PIN_LOW  = 8'h4C;
	localparam logic [7:0] ESC_BOOT     = 8'h53;
	localparam logic [7:0] ESC_CUSTOM   = 8'h43;

	typedef enum logic [2:0] {
		ACT_PRINT, ACT_MOVE, ACT_CLEAR, ACT_BEEP, ACT_LIGHT, ACT_GPIO
	} act_t;

	typedef enum logic [2:0] {
		EM_NONE, EM_PRINT, EM_MOVE, EM_CLEAR, EM_BEEP, EM_LIGHT, EM_GPIO
	} emit_t;

	typedef enum logic [3:0] {
		MV_HOME, MV_COL0, MV_ADV, MV_BACK, MV_LF, MV_RF,
		MV_COLSET, MV_LINESET, MV_CROW, MV_CCHAR
	} mv_t;

	typedef enum logic [1:0] {
		PR_BYTE, PR_DIGIT, PR_SPACE, PR_HEXV
	} pr_t;

	typedef enum logic [3:0] {
		UP_NONE, UP_GEO_LINES, UP_ACC_D, UP_GEO, UP_ACC_NIB, UP_DCNT_CLR,
		UP_DCNT_INC, UP_TAB, UP_CROW, UP_CC_INC, UP_CNT_CLR, UP_CNT_INC,
		UP_MOD_INIT, UP_MOD_STEP, UP_REM_INC
	} upd_t;

	typedef enum logic [4:0] {
		PM_IDLE, PM_SKIP, PM_ESC, PM_GEO_LINES, PM_GEO_TENS, PM_GEO_UNITS,
		PM_HEX_HI, PM_HEX_LO, PM_TAB, PM_COL_TENS, PM_COL_UNITS, PM_LINE,
		PM_GLYPH_NUM, PM_PIN, PM_BOOT, PM_CROW, PM_CCHAR
	} pm_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DEC, ST_PA_ADV, ST_B_SP, ST_B_ADV, ST_B_BK, ST_N_LF,
		ST_CL_MV, ST_CL_SP, ST_T_MOD, ST_T_SEL, ST_T_P, ST_T_A, ST_CC_P,
		ST_CC_H, ST_FLUSH
	} st_t;

	typedef struct packed {
		emit_t emit;
		mv_t   mv;
		pr_t   pr;
		upd_t  upd;
		logic  level;
		logic  flush;
	} dp_cmd_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       can_emit;
		logic       col_ge_end;
		logic       rem_zero;
		logic       cnt_lt_cols;
		logic       cnt_lt_tab;
		logic       mod_last;
		logic       hexv_le3;
		logic       dcnt_inc_lt8;
		logic       cc_ge_cols;
		logic       pin_ok;
	} dp_stat_t;

	localparam dp_cmd_t CMD_IDLE = '{emit: EM_NONE, mv: MV_HOME, pr: PR_BYTE,
		upd: UP_NONE, level: 1'b0, flush: 1'b0};

	function automatic logic hex_ok(input logic [7:0] b);
		return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
			(b >= 8'h41 && b <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_nib(input logic [7:0] b);
		logic [7:0] t;
		if (b >= 8'h61) begin
			t = b - LOWER_BASE;
		end else if (b >= 8'h41) begin
			t = b - UPPER_BASE;
		end else begin
			t = b - DIGIT_BASE;
		end
		return t[3:0];
	endfunction

endpackage

// ===== src/stdci_in_if.sv =====
// ----------------------------------------------------------------------------
// Byte input channel
// Valid/ready channel that carries one received serial byte.
// ----------------------------------------------------------------------------
interface stdci_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

// ===== src/stdci_out_if.sv =====
// ----------------------------------------------------------------------------
// Display action output channel
// Valid/ready channel that carries one display action.
// ----------------------------------------------------------------------------
interface stdci_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [7:0] value;
	logic       level;
	logic [3:0] line;
	logic [5:0] column;
	logic [8:0] pixel_x;
	logic [6:0] pixel_y;
	logic       last;

	modport source(output valid, output action, output value, output level, output line,
		output column, output pixel_x, output pixel_y, output last, input ready);
	modport sink(input valid, input action, input value, input level, input line,
		input column, input pixel_x, input pixel_y, input last, output ready);
endinterface

// ===== src/serial_text_display_command_interpreter.sv =====
// ----------------------------------------------------------------------------
// Serial text display command interpreter
// Interprets the character-display command language one byte at a time.
// ----------------------------------------------------------------------------
// Usage: received serial bytes enter on cmd_in (valid/ready); display actions
// leave on act_out (valid/ready), each with the cursor after the action and,
// for moves, the pixel position. The last action of a byte carries last = 1;
// a byte may cause no action at all.
// Timing: a byte is taken only when the previous one is finished. It is
// then decoded, any further actions are stepped out, a flush step marks
// the last action and the controller returns to idle. A tab first forms
// the remainder of the cursor column by the tab width, then picks the
// stop, then prints and advances once per space, and ends with the flush.
// The sequencer steps one action per cycle unless the output stalls.
// The newest action waits in the hold register so that the last one can be marked;
// the output register lets the next byte be taken while it waits.
// Reset: cursor at 0/0, 8 lines of 16 columns, tab width 3, idle parse mode.
// Stall: while act_out is stalled and both the hold and the output register are
// full, the sequencer waits; no action is lost or repeated.
// ----------------------------------------------------------------------------
module serial_text_display_command_interpreter #(
	parameter int unsigned GLYPH_WIDTH = 6,
	parameter int unsigned ROW_HEIGHT  = 8,
	parameter int unsigned MAX_COLUMNS = 49,
	parameter int unsigned GPIO_PINS   = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	stdci_in_if.sink    cmd_in,
	stdci_out_if.source act_out
);

	stdci_pkg::dp_cmd_t  cmd;
	stdci_pkg::dp_stat_t stat;
	logic                rdy, load;

	assign cmd_in.ready = rdy;
	assign load         = cmd_in.valid && rdy;

	stdci_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (load),
		.stat   (stat),
		.ready  (rdy),
		.cmd    (cmd)
	);

	stdci_dp #(
		.GLYPH_WIDTH (GLYPH_WIDTH),
		.ROW_HEIGHT  (ROW_HEIGHT),
		.MAX_COLUMNS (MAX_COLUMNS),
		.GPIO_PINS   (GPIO_PINS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.rx_byte (cmd_in.rx_byte),
		.cmd     (cmd),
		.stat    (stat),
		.act_out (act_out)
	);

endmodule

// ===== src/stdci_dp.sv =====
// ----------------------------------------------------------------------------
// Command interpreter datapath
// Display state, cursor arithmetic, loop counters and the action hold and
// output registers.
// ----------------------------------------------------------------------------
module stdci_dp #(
	parameter int unsigned GLYPH_WIDTH = 6,
	parameter int unsigned ROW_HEIGHT  = 8,
	parameter int unsigned MAX_COLUMNS = 49,
	parameter int unsigned GPIO_PINS   = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic [7:0]         rx_byte,
	input  stdci_pkg::dp_cmd_t cmd,
	output stdci_pkg::dp_stat_t stat,
	stdci_out_if.source        act_out
);

	localparam logic [2:0] MOD_TOP = 3'd5;

	logic [7:0] byte_q;
	logic [3:0] acc_q, dcnt_q, cl_q, lines_q, tab_q;
	logic [5:0] cc_q, cols_q, ccnt_q, cnt_q, rem_q, acnt_q;
	logic [1:0] crow_q;
	logic [2:0] k_q;

	logic       h_v_q, o_v_q;
	logic [2:0] h_act_q, o_act_q;
	logic [7:0] h_val_q, o_val_q;
	logic       h_lvl_q, o_lvl_q, o_last_q;
	logic [3:0] h_ln_q, o_ln_q;
	logic [5:0] h_col_q, o_col_q;
	logic [8:0] h_px_q, o_px_q;
	logic [6:0] h_py_q, o_py_q;

	logic [7:0]  d, hexv, val, colset;
	logic [3:0]  nib, lines_m1, tgt_l, nl, cl_inc;
	logic [5:0]  cols_m1, tgt_c, nc, rem_inc;
	logic [6:0]  col_inc;
	logic [11:0] geo_v, tab_sh;
	logic [2:0]  act;
	logic        lvl, ln_ok, want, do_emit, o_free;

	always_comb begin
		d        = byte_q - stdci_pkg::DIGIT_BASE;
		nib      = stdci_pkg::hex_nib(byte_q);
		hexv     = {acc_q, nib};
		cols_m1  = cols_q - 6'd1;
		lines_m1 = lines_q - 4'd1;
		col_inc  = {1'b0, cc_q} + 7'd1;
		cl_inc   = cl_q + 4'd1;
		colset   = 8'(acc_q) * 8'd10 + d;
		geo_v    = 12'(acc_q) * 12'd10 + 12'(d);
		tab_sh   = 12'(tab_q) << k_q;
		rem_inc  = rem_q + 6'd1;

		tgt_l = cl_q;
		tgt_c = cc_q;
		unique case (cmd.mv)
			stdci_pkg::MV_HOME: begin
				tgt_l = '0;
				tgt_c = '0;
			end
			stdci_pkg::MV_COL0: tgt_c = '0;
			stdci_pkg::MV_ADV: begin
				if (col_inc > {1'b0, cols_m1}) begin
					tgt_c = '0;
					tgt_l = (cl_inc > lines_m1) ? 4'd0 : cl_inc;
				end else begin
					tgt_c = col_inc[5:0];
				end
			end
			stdci_pkg::MV_BACK: begin
				if (cc_q == '0) begin
					tgt_l = (cl_q == '0) ? lines_m1 : cl_q - 4'd1;
					tgt_c = cols_m1;
				end else begin
					tgt_c = cc_q - 6'd1;
				end
			end
			stdci_pkg::MV_LF: tgt_l = (cl_inc > lines_m1) ? 4'd0 : cl_inc;
			stdci_pkg::MV_RF: tgt_l = (cl_q == '0) ? lines_m1 : cl_q - 4'd1;
			stdci_pkg::MV_COLSET: tgt_c = colset[5:0];
			stdci_pkg::MV_LINESET: tgt_l = d[3:0];
			stdci_pkg::MV_CROW: begin
				tgt_l = d[3:0];
				tgt_c = '0;
			end
			stdci_pkg::MV_CCHAR: begin
				tgt_l = {2'b00, crow_q};
				tgt_c = ccnt_q;
			end
			default: begin
				tgt_l = cl_q;
				tgt_c = cc_q;
			end
		endcase
		ln_ok = (tgt_l <= 4'd8);

		nl = cl_q;
		nc = cc_q;
		if (cmd.emit == stdci_pkg::EM_MOVE && ln_ok) begin
			nl = tgt_l;
			nc = tgt_c;
		end else if (cmd.emit == stdci_pkg::EM_CLEAR) begin
			nl = '0;
			nc = '0;
		end

		val = '0;
		lvl = 1'b0;
		act = stdci_pkg::ACT_PRINT;
		unique case (cmd.emit)
			stdci_pkg::EM_PRINT: begin
				act = stdci_pkg::ACT_PRINT;
				unique case (cmd.pr)
					stdci_pkg::PR_BYTE:  val = byte_q;
					stdci_pkg::PR_DIGIT: val = d;
					stdci_pkg::PR_SPACE: val = stdci_pkg::SPACE_CHAR;
					stdci_pkg::PR_HEXV:  val = hexv;
					default:             val = byte_q;
				endcase
			end
			stdci_pkg::EM_MOVE:  act = stdci_pkg::ACT_MOVE;
			stdci_pkg::EM_CLEAR: act = stdci_pkg::ACT_CLEAR;
			stdci_pkg::EM_BEEP:  act = stdci_pkg::ACT_BEEP;
			stdci_pkg::EM_LIGHT: begin
				act = stdci_pkg::ACT_LIGHT;
				val = hexv;
			end
			stdci_pkg::EM_GPIO: begin
				act = stdci_pkg::ACT_GPIO;
				val = d;
				lvl = cmd.level;
			end
			default: act = stdci_pkg::ACT_PRINT;
		endcase

		want    = (cmd.emit != stdci_pkg::EM_NONE) &&
			!(cmd.emit == stdci_pkg::EM_MOVE && !ln_ok);
		do_emit = want && (acnt_q < 6'(stdci_pkg::RESULT_LIMIT));
		o_free  = !o_v_q || act_out.ready;
	end

	always_comb begin
		stat.rx_byte      = byte_q;
		stat.can_emit     = !h_v_q || o_free;
		stat.col_ge_end   = (cc_q >= cols_m1);
		stat.rem_zero     = (rem_q == '0);
		stat.cnt_lt_cols  = (cnt_q < cols_q);
		stat.cnt_lt_tab   = (cnt_q < 6'(tab_q));
		stat.mod_last     = (k_q == '0);
		stat.hexv_le3     = (hexv <= 8'd3);
		stat.dcnt_inc_lt8 = ((dcnt_q + 4'd1) < 4'd8);
		stat.cc_ge_cols   = (ccnt_q >= cols_q);
		stat.pin_ok       = (d < 8'(GPIO_PINS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			dcnt_q  <= '0;
			cl_q    <= '0;
			cc_q    <= '0;
			lines_q <= 4'd8;
			cols_q  <= 6'd16;
			tab_q   <= 4'd3;
			crow_q  <= '0;
			ccnt_q  <= '0;
			cnt_q   <= '0;
			rem_q   <= '0;
			k_q     <= '0;
			acnt_q  <= '0;
			h_v_q   <= 1'b0;
			o_v_q   <= 1'b0;
		end else begin
			cl_q <= nl;
			cc_q <= nc;
			unique case (cmd.upd)
				stdci_pkg::UP_GEO_LINES: dcnt_q <= d[3:0];
				stdci_pkg::UP_ACC_D:     acc_q <= d[3:0];
				stdci_pkg::UP_GEO: begin
					lines_q <= dcnt_q;
					cols_q  <= (geo_v > 12'(MAX_COLUMNS)) ? 6'(MAX_COLUMNS) : geo_v[5:0];
				end
				stdci_pkg::UP_ACC_NIB:  acc_q <= nib;
				stdci_pkg::UP_DCNT_CLR: dcnt_q <= '0;
				stdci_pkg::UP_DCNT_INC: dcnt_q <= dcnt_q + 4'd1;
				stdci_pkg::UP_TAB:      tab_q <= d[3:0];
				stdci_pkg::UP_CROW: begin
					crow_q <= d[1:0];
					ccnt_q <= '0;
				end
				stdci_pkg::UP_CC_INC:  ccnt_q <= ccnt_q + 6'd1;
				stdci_pkg::UP_CNT_CLR: cnt_q <= '0;
				stdci_pkg::UP_CNT_INC: cnt_q <= cnt_q + 6'd1;
				stdci_pkg::UP_MOD_INIT: begin
					rem_q <= cc_q;
					k_q   <= MOD_TOP;
				end
				stdci_pkg::UP_MOD_STEP: begin
					// Restoring remainder: one shifted divisor per cycle.
					if (12'(rem_q) >= tab_sh) begin
						rem_q <= rem_q - tab_sh[5:0];
					end
					k_q <= k_q - 3'd1;
				end
				stdci_pkg::UP_REM_INC: rem_q <= (rem_inc == 6'(tab_q)) ? 6'd0 : rem_inc;
				default: ;
			endcase

			if (o_v_q && act_out.ready) begin
				o_v_q <= 1'b0;
			end
			if (h_v_q && (do_emit || cmd.flush)) begin
				o_v_q <= 1'b1;
			end
			if (cmd.flush) begin
				h_v_q  <= 1'b0;
				acnt_q <= '0;
			end else if (do_emit) begin
				h_v_q  <= 1'b1;
				acnt_q <= acnt_q + 6'd1;
			end
		end
	end

	// The newest action waits in the hold register until it is known whether
	// it is the last one of its byte.
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= rx_byte;
		end
		if (h_v_q && (do_emit || cmd.flush)) begin
			o_act_q  <= h_act_q;
			o_val_q  <= h_val_q;
			o_lvl_q  <= h_lvl_q;
			o_ln_q   <= h_ln_q;
			o_col_q  <= h_col_q;
			o_px_q   <= h_px_q;
			o_py_q   <= h_py_q;
			o_last_q <= cmd.flush;
		end
		if (do_emit) begin
			h_act_q <= act;
			h_val_q <= val;
			h_lvl_q <= lvl;
			h_ln_q  <= nl;
			h_col_q <= nc;
			h_px_q  <= (cmd.emit == stdci_pkg::EM_MOVE) ?
				9'(nc) * 9'(GLYPH_WIDTH) : 9'd0;
			h_py_q  <= (cmd.emit == stdci_pkg::EM_MOVE) ?
				7'(nl) * 7'(ROW_HEIGHT) : 7'd0;
		end
	end

	assign act_out.valid   = o_v_q;
	assign act_out.action  = o_act_q;
	assign act_out.value   = o_val_q;
	assign act_out.level   = o_lvl_q;
	assign act_out.line    = o_ln_q;
	assign act_out.column  = o_col_q;
	assign act_out.pixel_x = o_px_q;
	assign act_out.pixel_y = o_py_q;
	assign act_out.last    = o_last_q;

	a_acnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		acnt_q <= 6'(stdci_pkg::RESULT_LIMIT))
		else $error("action count exceeded the per-byte limit");

	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> !h_v_q && acnt_q == '0)
		else $error("hold register not empty after flush");

	a_hold_room: assert property (@(posedge clk) disable iff (!arst_n)
		(do_emit && h_v_q) |-> o_free)
		else $error("held action pushed into a full output register");

	a_line_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cl_q <= 4'd8)
		else $error("cursor line out of range");

endmodule

// ===== src/stdci_ctrl.sv =====
// ----------------------------------------------------------------------------
// Command interpreter controller
// Parse mode register and the sequencer that steps multi-action commands.
// ----------------------------------------------------------------------------
module stdci_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  stdci_pkg::dp_stat_t stat,
	output logic                ready,
	output stdci_pkg::dp_cmd_t  cmd
);

	stdci_pkg::st_t st_q, st_d;
	stdci_pkg::pm_t pm_q, pm_d;
	logic [7:0]     pend_q, pend_d;
	logic           tb_q, tb_d;

	stdci_pkg::dp_cmd_t c;
	logic [7:0]         b, d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= stdci_pkg::ST_IDLE;
			pm_q   <= stdci_pkg::PM_IDLE;
			pend_q <= '0;
			tb_q   <= 1'b0;
		end else begin
			st_q   <= st_d;
			pm_q   <= pm_d;
			pend_q <= pend_d;
			tb_q   <= tb_d;
		end
	end

	always_comb begin
		st_d   = st_q;
		pm_d   = pm_q;
		pend_d = pend_q;
		tb_d   = tb_q;
		c      = stdci_pkg::CMD_IDLE;
		ready  = 1'b0;
		b      = stat.rx_byte;
		d      = b - stdci_pkg::DIGIT_BASE;

		unique case (st_q)
			stdci_pkg::ST_IDLE: begin
				ready = 1'b1;
				if (start) begin
					st_d = stdci_pkg::ST_DEC;
				end
			end
			stdci_pkg::ST_DEC: begin
				pm_d = stdci_pkg::PM_IDLE;
				st_d = stdci_pkg::ST_FLUSH;
				unique case (pm_q)
					stdci_pkg::PM_IDLE: begin
						if (b == stdci_pkg::SKIP_BYTE) begin
							pm_d = stdci_pkg::PM_SKIP;
						end else if (b == stdci_pkg::ESC_START) begin
							pm_d = stdci_pkg::PM_ESC;
						end else if (b >= stdci_pkg::PRINT_LO && b <= stdci_pkg::PRINT_HI) begin
							c.emit = stdci_pkg::EM_PRINT;
							c.pr   = stdci_pkg::PR_BYTE;
							st_d   = stdci_pkg::ST_PA_ADV;
						end
					end
					stdci_pkg::PM_ESC: begin
						pend_d = b;
						if (d <= 8'd7) begin
							c.emit = stdci_pkg::EM_PRINT;
							c.pr   = stdci_pkg::PR_DIGIT;
							st_d   = stdci_pkg::ST_PA_ADV;
						end else begin
							unique case (b)
								stdci_pkg::ESC_HOME: begin
									c.emit = stdci_pkg::EM_MOVE;
									c.mv   = stdci_pkg::MV_HOME;
								end
								stdci_pkg::ESC_BKSP: begin
									c.emit = stdci_pkg::EM_MOVE;
									c.mv   = stdci_pkg::MV_BACK;
									st_d   = stdci_pkg::ST_B_SP;
								end
								stdci_pkg::ESC_CLEAR: c.emit = stdci_pkg::EM_CLEAR;
								stdci_pkg::ESC_BEEP:  c.emit = stdci_pkg::EM_BEEP;
								stdci_pkg::ESC_GEOM:  pm_d = stdci_pkg::PM_GEO_LINES;
								stdci_pkg::ESC_LIGHT_B, stdci_pkg::ESC_LIGHT_E,
								stdci_pkg::ESC_INIT:  pm_d = stdci_pkg::PM_HEX_HI;
								stdci_pkg::ESC_GLYPH: pm_d = stdci_pkg::PM_GLYPH_NUM;
								stdci_pkg::ESC_BACK: begin
									c.emit = stdci_pkg::EM_MOVE;
									c.mv   = stdci_pkg::MV_BACK;
								end
								stdci_pkg::ESC_FWD: begin
									c.emit = stdci_pkg::EM_MOVE;
									c.mv   = stdci_pkg::MV_ADV;
								end
								stdci_pkg::ESC_RFEED: begin
									c.emit = stdci_pkg::EM_MOVE;
									c.mv   = stdci_pkg::MV_RF;
								end
								stdci_pkg::ESC_LFEED: begin
									c.emit = stdci_pkg::EM_MOVE;
									c.mv   = stdci_pkg::MV_LF;
								end
								stdci_pkg::ESC_CLRLINE: begin
									c.emit = stdci_pkg::EM_MOVE;
									c.mv   = stdci_pkg::MV_COL0;
									c.upd  = stdci_pkg::UP_CNT_CLR;
									st_d   = stdci_pkg::ST_CL_SP;
								end
								stdci_pkg::ESC_CRET: begin
									c.emit = stdci_pkg::EM_MOVE;
									c.mv   = stdci_pkg::MV_COL0;
								end
								stdci_pkg::ESC_NEWLINE: begin
									c.emit = stdci_pkg::EM_MOVE;
									c.mv   = stdci_pkg::MV_COL0;
									st_d   = stdci_pkg::ST_N_LF;
								end
								stdci_pkg::ESC_TABSIZE: pm_d = stdci_pkg::PM_TAB;
								stdci_pkg::ESC_TAB: begin
									if (!stat.col_ge_end) begin
										c.upd = stdci_pkg::UP_MOD_INIT;
										st_d  = stdci_pkg::ST_T_MOD;
									end
								end
								stdci_pkg::ESC_COLUMN: pm_d = stdci_pkg::PM_COL_TENS;
								stdci_pkg::ESC_LINE:   pm_d = stdci_pkg::PM_LINE;
								stdci_pkg::ESC_START: begin
									c.emit = stdci_pkg::EM_PRINT;
									c.pr   = stdci_pkg::PR_BYTE;
									st_d   = stdci_pkg::ST_PA_ADV;
								end
								stdci_pkg::ESC_PIN_HIGH,
								stdci_pkg::ESC_PIN_LOW: pm_d = stdci_pkg::PM_PIN;
								stdci_pkg::ESC_BOOT:    pm_d = stdci_pkg::PM_BOOT;
								stdci_pkg::ESC_CUSTOM:  pm_d = stdci_pkg::PM_CROW;
								default: ;
							endcase
						end
					end
					stdci_pkg::PM_GEO_LINES: begin
						if (d >= 8'd2 && d <= 8'd4) begin
							c.upd = stdci_pkg::UP_GEO_LINES;
							pm_d  = stdci_pkg::PM_GEO_TENS;
						end
					end
					stdci_pkg::PM_GEO_TENS: begin
						if (d >= 8'd1 && d <= 8'd4) begin
							c.upd = stdci_pkg::UP_ACC_D;
							pm_d  = stdci_pkg::PM_GEO_UNITS;
						end
					end
					stdci_pkg::PM_GEO_UNITS: begin
						if (d <= 8'd9) begin
							c.upd = stdci_pkg::UP_GEO;
						end
					end
					stdci_pkg::PM_HEX_HI: begin
						if (stdci_pkg::hex_ok(b)) begin
							c.upd = stdci_pkg::UP_ACC_NIB;
							pm_d  = stdci_pkg::PM_HEX_LO;
						end
					end
					stdci_pkg::PM_HEX_LO: begin
						if (stdci_pkg::hex_ok(b)) begin
							if (pend_q == stdci_pkg::ESC_LIGHT_B ||
								pend_q == stdci_pkg::ESC_LIGHT_E) begin
								c.emit = stdci_pkg::EM_LIGHT;
							end else if (pend_q == stdci_pkg::ESC_INIT) begin
								if (stat.hexv_le3) begin
									c.emit = stdci_pkg::EM_PRINT;
									c.pr   = stdci_pkg::PR_HEXV;
								end
							end else if (pend_q == stdci_pkg::ESC_GLYPH) begin
								c.upd = stdci_pkg::UP_DCNT_INC;
								if (stat.dcnt_inc_lt8) begin
									pm_d = stdci_pkg::PM_HEX_HI;
								end
							end
						end
					end
					stdci_pkg::PM_TAB: begin
						if (d >= 8'd1 && d <= 8'd8) begin
							c.upd = stdci_pkg::UP_TAB;
						end
					end
					stdci_pkg::PM_COL_TENS: begin
						if (d <= 8'd3) begin
							c.upd = stdci_pkg::UP_ACC_D;
							pm_d  = stdci_pkg::PM_COL_UNITS;
						end
					end
					stdci_pkg::PM_COL_UNITS: begin
						if (d <= 8'd9) begin
							c.emit = stdci_pkg::EM_MOVE;
							c.mv   = stdci_pkg::MV_COLSET;
						end
					end
					stdci_pkg::PM_LINE: begin
						if (d <= 8'd3) begin
							c.emit = stdci_pkg::EM_MOVE;
							c.mv   = stdci_pkg::MV_LINESET;
						end
					end
					stdci_pkg::PM_GLYPH_NUM: begin
						if (d <= 8'd7) begin
							c.upd = stdci_pkg::UP_DCNT_CLR;
							pm_d  = stdci_pkg::PM_HEX_HI;
						end
					end
					stdci_pkg::PM_PIN: begin
						if (stat.pin_ok) begin
							c.emit  = stdci_pkg::EM_GPIO;
							c.level = (pend_q == stdci_pkg::ESC_PIN_HIGH);
						end
					end
					stdci_pkg::PM_CROW: begin
						if (d <= 8'd3) begin
							c.emit = stdci_pkg::EM_MOVE;
							c.mv   = stdci_pkg::MV_CROW;
							c.upd  = stdci_pkg::UP_CROW;
							pm_d   = stdci_pkg::PM_CCHAR;
						end
					end
					stdci_pkg::PM_CCHAR: begin
						c.emit = stdci_pkg::EM_MOVE;
						c.mv   = stdci_pkg::MV_CCHAR;
						st_d   = stdci_pkg::ST_CC_P;
					end
					default: ;
				endcase
			end
			stdci_pkg::ST_PA_ADV: begin
				c.emit = stdci_pkg::EM_MOVE;
				c.mv   = stdci_pkg::MV_ADV;
				st_d   = stdci_pkg::ST_FLUSH;
			end
			stdci_pkg::ST_B_SP: begin
				c.emit = stdci_pkg::EM_PRINT;
				c.pr   = stdci_pkg::PR_SPACE;
				st_d   = stdci_pkg::ST_B_ADV;
			end
			stdci_pkg::ST_B_ADV: begin
				c.emit = stdci_pkg::EM_MOVE;
				c.mv   = stdci_pkg::MV_ADV;
				st_d   = stdci_pkg::ST_B_BK;
			end
			stdci_pkg::ST_B_BK: begin
				c.emit = stdci_pkg::EM_MOVE;
				c.mv   = stdci_pkg::MV_BACK;
				st_d   = stdci_pkg::ST_FLUSH;
			end
			stdci_pkg::ST_N_LF: begin
				c.emit = stdci_pkg::EM_MOVE;
				c.mv   = stdci_pkg::MV_LF;
				c.upd  = stdci_pkg::UP_CNT_CLR;
				st_d   = stdci_pkg::ST_CL_MV;
			end
			stdci_pkg::ST_CL_MV: begin
				c.emit = stdci_pkg::EM_MOVE;
				c.mv   = stdci_pkg::MV_COL0;
				st_d   = stdci_pkg::ST_CL_SP;
			end
			stdci_pkg::ST_CL_SP: begin
				if (stat.cnt_lt_cols) begin
					c.emit = stdci_pkg::EM_PRINT;
					c.pr   = stdci_pkg::PR_SPACE;
					c.upd  = stdci_pkg::UP_CNT_INC;
				end else begin
					c.emit = stdci_pkg::EM_MOVE;
					c.mv   = stdci_pkg::MV_COL0;
					st_d   = stdci_pkg::ST_FLUSH;
				end
			end
			stdci_pkg::ST_T_MOD: begin
				c.upd = stdci_pkg::UP_MOD_STEP;
				if (stat.mod_last) begin
					st_d = stdci_pkg::ST_T_SEL;
				end
			end
			stdci_pkg::ST_T_SEL: begin
				// On a tab stop a full tab width is printed, otherwise up to the next stop.
				tb_d  = stat.rem_zero;
				c.upd = stdci_pkg::UP_CNT_CLR;
				st_d  = stdci_pkg::ST_T_P;
			end
			stdci_pkg::ST_T_P: begin
				if (!stat.col_ge_end && (tb_q ? stat.cnt_lt_tab : !stat.rem_zero)) begin
					c.emit = stdci_pkg::EM_PRINT;
					c.pr   = stdci_pkg::PR_SPACE;
					c.upd  = stdci_pkg::UP_CNT_INC;
					st_d   = stdci_pkg::ST_T_A;
				end else begin
					st_d = stdci_pkg::ST_FLUSH;
				end
			end
			stdci_pkg::ST_T_A: begin
				c.emit = stdci_pkg::EM_MOVE;
				c.mv   = stdci_pkg::MV_ADV;
				c.upd  = stdci_pkg::UP_REM_INC;
				st_d   = stdci_pkg::ST_T_P;
			end
			stdci_pkg::ST_CC_P: begin
				c.emit = stdci_pkg::EM_PRINT;
				c.pr   = stdci_pkg::PR_BYTE;
				c.upd  = stdci_pkg::UP_CC_INC;
				st_d   = stdci_pkg::ST_CC_H;
			end
			stdci_pkg::ST_CC_H: begin
				if (stat.cc_ge_cols) begin
					c.emit = stdci_pkg::EM_MOVE;
					c.mv   = stdci_pkg::MV_HOME;
					pm_d   = stdci_pkg::PM_IDLE;
				end else begin
					pm_d = stdci_pkg::PM_CCHAR;
				end
				st_d = stdci_pkg::ST_FLUSH;
			end
			stdci_pkg::ST_FLUSH: begin
				c.flush = 1'b1;
				st_d    = stdci_pkg::ST_IDLE;
			end
			default: st_d = stdci_pkg::ST_IDLE;
		endcase

		// A step that produces a transaction waits until the hold register can drain.
		if ((c.emit != stdci_pkg::EM_NONE || c.flush) && !stat.can_emit) begin
			c      = stdci_pkg::CMD_IDLE;
			st_d   = st_q;
			pm_d   = pm_q;
			pend_d = pend_q;
			tb_d   = tb_q;
		end
		cmd = c;
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ready |-> (st_q == stdci_pkg::ST_IDLE))
		else $error("ready outside idle");

	a_start_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(ready && start) |=> (st_q == stdci_pkg::ST_DEC))
		else $error("accepted byte not decoded");

	a_flush_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> (st_q == stdci_pkg::ST_IDLE))
		else $error("flush did not end the byte");

endmodule
